/* hw/rtl/whe_pkg.sv */
// Weighted heading estimator: shared constants.
// No dependencies.
`timescale 1ns / 1ps

package whe_pkg;

    localparam int HISTORY_DEPTH_DEF = 32;

    localparam logic [2:0] SRC_DISABLED = 3'd0;
    localparam logic [2:0] SRC_FIXED    = 3'd1;
    localparam logic [2:0] SRC_FEW      = 3'd2;
    localparam logic [2:0] SRC_COMPUTED = 3'd3;
    localparam logic [2:0] SRC_ZERO     = 3'd4;

    localparam logic [2:0] REG_ENABLE  = 3'd0;
    localparam logic [2:0] REG_KERNEL  = 3'd1;
    localparam logic [2:0] REG_DECAY   = 3'd2;
    localparam logic [2:0] REG_HISTORY = 3'd3;
    localparam logic [2:0] REG_FIXX    = 3'd4;
    localparam logic [2:0] REG_FIXY    = 3'd5;

    localparam logic [16:0] WEIGHT_ONE = 17'd65536;

endpackage

/* hw/rtl/weighted_heading_estimator.sv */
// Weighted heading estimator top level: ring, sequencer and shared datapath.
// Depends on whe_pkg.
`timescale 1ns / 1ps
//
//  channel | signals                              | handshake
//  --------+--------------------------------------+-----------
//  in      | pos_x, pos_y                         | in_valid / in_ready
//  out     | heading_x, heading_y, source         | out_valid / out_ready
//  cfg     | cfg_we, cfg_index, cfg_data          | write enable, no wait
//
//  One item at a time. The walk over the n held positions does one
//  registered ring read per step and uses one shared multiplier for both
//  products and the weight update; scaling then shifts both magnitudes into
//  range, followed by the two squares, the square root and the two restoring
//  divisions. Disabled, override and too-few items pass S_DECIDE and S_OUT
//  before out_valid rises. Reset clears pointer, count and configuration
//  registers; the ring holds no reset value and no unwritten entry is ever
//  used. The result waits in the output register until taken; in_ready is low
//  from acceptance until then.
module weighted_heading_estimator
    import whe_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] heading_x,
    output logic signed [15:0] heading_y,
    output logic [2:0]         source,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [16:0]        cfg_data
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_RD, S_WAIT, S_MUL, S_ACC, S_CHK, S_NORMR, S_NORML,
        S_SQR, S_SQRT, S_DIV, S_SIGN, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic        enable_reg, kernel_reg;
    logic [16:0] decay_reg;
    logic [5:0]  hist_reg;
    logic [15:0] fixx_reg, fixy_reg;

    logic [AW-1:0] wptr_reg;
    logic [CW-1:0] count_reg;

    logic [47:0] ring [HISTORY_DEPTH];
    logic [47:0] rdata_reg;
    logic [AW-1:0] raddr_reg;

    // window length, clamped to 1..HISTORY_DEPTH
    logic [CW-1:0] win_len;
    always_comb
    begin
        if (hist_reg == 6'd0)
            win_len = CW'(1);
        else if (32'(hist_reg) > HISTORY_DEPTH)
            win_len = CW'(HISTORY_DEPTH);
        else
            win_len = CW'(hist_reg);
    end

    // window length that a history write sets, clamped the same way
    logic [CW-1:0] cfg_win;
    always_comb
    begin
        if (cfg_data[5:0] == 6'd0)
            cfg_win = CW'(1);
        else if (32'(cfg_data[5:0]) > HISTORY_DEPTH)
            cfg_win = CW'(HISTORY_DEPTH);
        else
            cfg_win = CW'(cfg_data[5:0]);
    end

    logic [16:0] decay_eff;
    assign decay_eff = (decay_reg > WEIGHT_ONE) ? WEIGHT_ONE : decay_reg;

    // datapath registers
    logic signed [24:0] prev_x_reg, prev_y_reg;
    logic signed [24:0] dx_reg, dy_reg;
    logic [16:0]        w_reg;
    logic signed [63:0] sx_reg, sy_reg;
    logic signed [42:0] px_reg, py_reg;
    logic [CW-1:0]      left_reg;
    logic               first_reg;
    logic [63:0]        ax_reg, ay_reg;
    logic               negx_reg, negy_reg;
    logic [63:0]        rem_reg, res_reg, bit_reg;
    logic [63:0]        sq_reg;
    logic [5:0]         cnt_reg;
    logic               divy_reg;
    logic [45:0]        num_reg;
    logic [31:0]        len_reg;
    logic [15:0]        q_reg, hx_reg;
    logic signed [15:0] hxo_reg, hyo_reg;
    logic [2:0]         src_reg;
    logic               ovalid_reg;

    // one shared multiplier: displacement x weight, weight x decay
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;
    logic [1:0]         mul_sel_reg;
    always_comb
    begin
        case (mul_sel_reg)
            2'd0:    begin mul_a = 33'(dx_reg); mul_b = 18'($signed({1'b0, w_reg})); end
            2'd1:    begin mul_a = 33'(dy_reg); mul_b = 18'($signed({1'b0, w_reg})); end
            default: begin mul_a = 33'($signed({16'd0, w_reg}));
                           mul_b = 18'($signed({1'b0, decay_eff})); end
        endcase
        mul_p = 51'(mul_a) * 51'(mul_b);
    end

    logic [63:0] mx;
    assign mx = (ax_reg > ay_reg) ? ax_reg : ay_reg;

    // square of a 31-bit magnitude on the 32x32 multiplier
    logic [31:0] sq_in;
    assign sq_in = cnt_reg[0] ? ay_reg[31:0] : ax_reg[31:0];

    logic [63:0] sqrt_t;
    assign sqrt_t = res_reg + bit_reg;

    logic [46:0] div_trial;
    assign div_trial = {num_reg, 1'b0} - {15'd0, len_reg};

    assign in_ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign heading_x = hxo_reg;
    assign heading_y = hyo_reg;
    assign source    = src_reg;

    // ring: written on accept, read one entry per walk step
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            ring[wptr_reg] <= {pos_x, pos_y};
        rdata_reg <= ring[raddr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            enable_reg <= 1'b0;
            kernel_reg <= 1'b0;
            decay_reg  <= WEIGHT_ONE;
            hist_reg   <= 6'd32;
            fixx_reg   <= '0;
            fixy_reg   <= '0;
            wptr_reg   <= '0;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ENABLE:  enable_reg <= cfg_data[0];
                    REG_KERNEL:  kernel_reg <= cfg_data[0];
                    REG_DECAY:   decay_reg  <= cfg_data;
                    REG_HISTORY: hist_reg   <= cfg_data[5:0];
                    REG_FIXX:    fixx_reg   <= cfg_data[15:0];
                    REG_FIXY:    fixy_reg   <= cfg_data[15:0];
                    default: ;
                endcase
            end
            // a shorter window drops the oldest positions at once
            if (cfg_we && cfg_index == REG_HISTORY)
            begin
                if (count_reg > cfg_win)
                    count_reg <= cfg_win;
            end
            else if (in_valid && in_ready && count_reg < win_len)
                count_reg <= count_reg + 1'b1;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        wptr_reg <= (wptr_reg == LAST_ADDR) ? '0 : wptr_reg + 1'b1;
                        raddr_reg <= wptr_reg;
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    sx_reg    <= '0;
                    sy_reg    <= '0;
                    w_reg     <= WEIGHT_ONE;
                    first_reg <= 1'b1;
                    left_reg  <= count_reg;
                    hxo_reg   <= '0;
                    hyo_reg   <= '0;
                    if (!enable_reg)
                    begin
                        src_reg <= SRC_DISABLED; state_reg <= S_OUT;
                    end
                    else if (fixx_reg != 16'd0 || fixy_reg != 16'd0)
                    begin
                        hxo_reg <= fixx_reg; hyo_reg <= fixy_reg;
                        src_reg <= SRC_FIXED; state_reg <= S_OUT;
                    end
                    else if (count_reg < CW'(2))
                    begin
                        src_reg <= SRC_FEW; state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_RD;
                end
                S_RD:
                begin
                    // rdata_reg holds entry raddr; step back one entry
                    raddr_reg <= (raddr_reg == '0) ? LAST_ADDR : raddr_reg - 1'b1;
                    left_reg  <= left_reg - 1'b1;
                    prev_x_reg <= 25'($signed(rdata_reg[47:24]));
                    prev_y_reg <= 25'($signed(rdata_reg[23:0]));
                    dx_reg <= prev_x_reg - 25'($signed(rdata_reg[47:24]));
                    dy_reg <= prev_y_reg - 25'($signed(rdata_reg[23:0]));
                    if (first_reg)
                    begin
                        first_reg <= 1'b0;
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        mul_sel_reg <= 2'd0;
                        state_reg   <= S_MUL;
                    end
                end
                S_WAIT:
                    // the ring read is registered, so wait for data at the new address
                    state_reg <= S_RD;
                S_MUL:
                begin
                    px_reg      <= mul_p[42:0];
                    mul_sel_reg <= 2'd1;
                    state_reg   <= S_ACC;
                end
                S_ACC:
                begin
                    py_reg      <= mul_p[42:0];
                    sx_reg      <= sx_reg + 64'(px_reg);
                    mul_sel_reg <= 2'd2;
                    state_reg   <= S_CHK;
                end
                S_CHK:
                begin
                    sy_reg <= sy_reg + 64'(py_reg);
                    if (kernel_reg)
                        w_reg <= 17'((51'(mul_p) + 51'd32768) >>> 16);
                    if (left_reg != '0)
                        state_reg <= S_RD;
                    else
                        state_reg <= S_NORMR;
                    cnt_reg <= '0;
                end
                S_NORMR:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        cnt_reg  <= 6'd1;
                        negx_reg <= sx_reg[63];
                        negy_reg <= sy_reg[63];
                        ax_reg   <= sx_reg[63] ? 64'(-sx_reg) : 64'(sx_reg);
                        ay_reg   <= sy_reg[63] ? 64'(-sy_reg) : 64'(sy_reg);
                        if (sx_reg == 64'sd0 && sy_reg == 64'sd0)
                        begin
                            src_reg <= SRC_ZERO; state_reg <= S_OUT;
                        end
                    end
                    else if (mx[63:31] != '0)
                    begin
                        ax_reg <= ax_reg >> 1; ay_reg <= ay_reg >> 1;
                    end
                    else
                        state_reg <= S_NORML;
                end
                S_NORML:
                begin
                    if (mx[30] == 1'b0)
                    begin
                        ax_reg <= ax_reg << 1; ay_reg <= ay_reg << 1;
                    end
                    else
                    begin
                        cnt_reg   <= 6'd0;
                        state_reg <= S_SQR;
                    end
                end
                S_SQR:
                begin
                    // two squares through the shared 32-bit product path
                    if (cnt_reg == 6'd0)
                    begin
                        sq_reg  <= 64'(sq_in) * 64'(sq_in);
                        cnt_reg <= 6'd1;
                    end
                    else
                    begin
                        rem_reg   <= sq_reg + 64'(sq_in) * 64'(sq_in);
                        res_reg   <= '0;
                        bit_reg   <= 64'd1 << 62;
                        cnt_reg   <= 6'd0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (bit_reg == '0)
                    begin
                        len_reg   <= res_reg[31:0];
                        num_reg   <= 46'({ax_reg[31:0], 14'd0} + 46'(res_reg[31:1]));
                        q_reg     <= '0;
                        cnt_reg   <= 6'd0;
                        divy_reg  <= 1'b0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        if (rem_reg >= sqrt_t)
                        begin
                            rem_reg <= rem_reg - sqrt_t;
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end
                        else
                            res_reg <= res_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                    end
                end
                S_DIV:
                begin
                    // quotient fits in 15 bits; numerator shifted one bit a step
                    if (cnt_reg == 6'd0)
                    begin
                        // rem in upper part: start with numerator high bits zero
                        rem_reg <= '0;
                        cnt_reg <= 6'd46;
                    end
                    else
                    begin
                        logic [32:0] r;
                        r = {rem_reg[31:0], num_reg[45]};
                        num_reg <= {num_reg[44:0], 1'b0};
                        if (r >= 33'(len_reg))
                        begin
                            rem_reg <= 64'(r - 33'(len_reg));
                            q_reg   <= {q_reg[14:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= 64'(r);
                            q_reg   <= {q_reg[14:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 1'b1;
                        if (cnt_reg == 6'd1)
                            state_reg <= S_SIGN;
                    end
                end
                S_SIGN:
                begin
                    if (!divy_reg)
                    begin
                        hx_reg    <= q_reg;
                        divy_reg  <= 1'b1;
                        num_reg   <= 46'({ay_reg[31:0], 14'd0} + 46'(len_reg[31:1]));
                        q_reg     <= '0;
                        cnt_reg   <= 6'd0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        hxo_reg   <= negx_reg ? -hx_reg : hx_reg;
                        hyo_reg   <= negy_reg ? -q_reg : q_reg;
                        src_reg   <= SRC_COMPUTED;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("accept while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= HISTORY_DEPTH) else $error("count overflow");
    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> out_valid) else $error("result lost");
    a_src_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (source <= SRC_ZERO)) else $error("bad source");

endmodule

/* tb/whe_checker.sv */
// Checker for the weighted heading estimator: predicts each heading and compares.
// Depends on whe_pkg; watches the item channels and the register port of the block.
`timescale 1ns / 1ps

module whe_checker
    import whe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] heading_x,
    input  logic signed [15:0] heading_y,
    input  logic [2:0]         source,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    output int                 errors,
    output int                 pending
);

    localparam int DEPTH = HISTORY_DEPTH_DEF;

    typedef struct packed {
        logic [15:0] hx;
        logic [15:0] hy;
        logic [2:0]  src;
    } heading_t;

    heading_t heading_q[$];

    logic signed [23:0] trail_x [DEPTH];
    logic signed [23:0] trail_y [DEPTH];
    int unsigned wr_ptr, held;
    logic        en_r, expo_r;
    logic [16:0] decay_r;
    logic [5:0]  hist_r;
    logic [15:0] fx_r, fy_r;

    assign pending = heading_q.size();

    function automatic int unsigned win_len();
        int unsigned l;
        l = hist_r;
        if (l < 1) l = 1;
        if (l > DEPTH) l = DEPTH;
        return l;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // record the position, then work out the heading it gives
    function automatic heading_t push_and_estimate(logic signed [23:0] px,
                                                   logic signed [23:0] py);
        heading_t h;
        int unsigned k, i0, i1, d;
        longint unsigned w, ax, ay, mx, len, hx, hy;
        longint sx, sy;
        bit nx, ny;
        trail_x[wr_ptr] = px;
        trail_y[wr_ptr] = py;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        if (held < win_len()) held++;
        h = '0;
        if (!en_r) begin h.src = SRC_DISABLED; return h; end
        if (fx_r != 0 || fy_r != 0)
        begin
            h.hx = fx_r; h.hy = fy_r; h.src = SRC_FIXED;
            return h;
        end
        if (held < 2) begin h.src = SRC_FEW; return h; end
        d = (decay_r > WEIGHT_ONE) ? WEIGHT_ONE : decay_r;
        w = WEIGHT_ONE;
        sx = 0; sy = 0;
        for (k = 0; k + 1 < held; k++)
        begin
            i0 = (wr_ptr + DEPTH - 1 - k) % DEPTH;
            i1 = (wr_ptr + DEPTH - 2 - k) % DEPTH;
            sx += (longint'(trail_x[i0]) - longint'(trail_x[i1])) * longint'(w);
            sy += (longint'(trail_y[i0]) - longint'(trail_y[i1])) * longint'(w);
            if (expo_r) w = (w * d + 32768) >> 16;
        end
        if (sx == 0 && sy == 0) begin h.src = SRC_ZERO; return h; end
        nx = sx < 0; ny = sy < 0;
        ax = nx ? -sx : sx;
        ay = ny ? -sy : sy;
        mx = ax > ay ? ax : ay;
        while (mx >= (64'd1 << 31)) begin ax >>= 1; ay >>= 1; mx >>= 1; end
        while (mx < (64'd1 << 30)) begin ax <<= 1; ay <<= 1; mx <<= 1; end
        len = root64(ax * ax + ay * ay);
        hx = (ax * 16384 + len / 2) / len;
        hy = (ay * 16384 + len / 2) / len;
        if (hx > 16384) hx = 16384;
        if (hy > 16384) hy = 16384;
        h.hx = nx ? 16'(-hx) : 16'(hx);
        h.hy = ny ? 16'(-hy) : 16'(hy);
        h.src = SRC_COMPUTED;
        return h;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        heading_t e;
        if (!rst_n)
        begin
            heading_q.delete();
            wr_ptr = 0; held = 0;
            en_r = 0; expo_r = 0; decay_r = WEIGHT_ONE; hist_r = 32;
            fx_r = 0; fy_r = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (heading_q.size() == 0)
                    report_mismatch("unexpected item, source", source, -1);
                else
                begin
                    e = heading_q[0];
                    heading_q.delete(0);
                    if (heading_x !== e.hx)
                        report_mismatch("heading_x", heading_x, $signed(e.hx));
                    if (heading_y !== e.hy)
                        report_mismatch("heading_y", heading_y, $signed(e.hy));
                    if (source !== e.src)
                        report_mismatch("source", source, e.src);
                end
            end
            if (in_valid && in_ready)
                heading_q.insert(heading_q.size(), push_and_estimate(pos_x, pos_y));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ENABLE:  en_r = cfg_data[0];
                    REG_KERNEL:  expo_r = cfg_data[0];
                    REG_DECAY:   decay_r = cfg_data;
                    REG_HISTORY:
                    begin
                        hist_r = cfg_data[5:0];
                        if (held > win_len()) held = win_len();
                    end
                    REG_FIXX:    fx_r = cfg_data[15:0];
                    REG_FIXY:    fy_r = cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* tb/tb_top.sv */
// Top of the heading estimator testbench: clock, reset, stimulus and verdict.
// Depends on whe_pkg, whe_checker and the block weighted_heading_estimator.
`timescale 1ns / 1ps

module tb_top;
    import whe_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] heading_x;
    logic signed [15:0] heading_y;
    logic [2:0]         source;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [16:0]        cfg_data;
    int                 errors;
    int                 pending;

    // receiver control: the long hold-off overrides the random stall pattern
    bit hold_req;
    bit hold_off;
    bit sink_stall;

    weighted_heading_estimator dut (.*);
    whe_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Run limit: the slowest correct run of about 1900 items plus stalls stays
    // well under 2M ns; allow a few times that.
    initial
    begin
        #8000000;
        $display("FAIL");
        $finish;
    end

    // Receiver: stalls in short runs of its own, or holds off entirely.
    initial
    begin
        int run;
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (run > 0)
                run--;
            else
            begin
                sink_stall = ($urandom_range(0, 3) == 0);
                run = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 40);
            end
            out_ready <= !hold_off && !sink_stall;
        end
    end

    // Offer one item; holds valid and payload until accepted.
    task automatic send_pos(logic signed [23:0] x, logic signed [23:0] y);
        pos_x <= x;
        pos_y <= y;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Gap between items; valid drops only when no item follows at once.
    task automatic sender_gap();
        int g;
        if ($urandom_range(0, 2) != 0) return;
        g = $urandom_range(1, 12);
        in_valid <= 0;
        repeat (g) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [16:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // Registers only change once the block has drained.
    task automatic wait_idle();
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    function automatic logic signed [23:0] rand_coord(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
            default: return 24'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    // Random setting: enabled mostly, override rarely, all windows; decay 0, unity, over unity or 30000..65535.
    task automatic random_setting();
        int s;
        s = $urandom_range(0, 9);
        write_reg(REG_ENABLE, 17'(s != 0));
        write_reg(REG_KERNEL, 17'($urandom_range(0, 1)));
        case ($urandom_range(0, 4))
            0: write_reg(REG_DECAY, 17'd0);
            1: write_reg(REG_DECAY, WEIGHT_ONE);
            2: write_reg(REG_DECAY, 17'($urandom_range(65537, 131071)));
            default: write_reg(REG_DECAY, 17'($urandom_range(30000, 65535)));
        endcase
        write_reg(REG_HISTORY, ($urandom_range(0, 4) == 0) ? 17'($urandom_range(0, 63))
                                                            : 17'($urandom_range(1, 8)));
        if (s == 1)
        begin
            write_reg(REG_FIXX, 17'($urandom_range(0, 65535)));
            write_reg(REG_FIXY, 17'($urandom_range(0, 65535)));
        end
        else
        begin
            write_reg(REG_FIXX, 17'd0);
            write_reg(REG_FIXY, 17'd0);
        end
    endtask

    initial
    begin
        int i, mode, burst;
        logic signed [23:0] bx, by;
        rst_n = 0;
        in_valid = 0;
        pos_x = 0;
        pos_y = 0;
        cfg_we = 0;
        cfg_index = REG_ENABLE;
        cfg_data = 0;
        hold_req = 0;
        repeat (7) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: disabled at reset, then too few samples, extremes, zero sum
        send_pos(24'sh7FFFFF, -24'sh800000);
        wait_idle();
        write_reg(REG_ENABLE, 17'd1);
        write_reg(REG_HISTORY, 17'd32);
        send_pos(24'sd0, 24'sd0);
        send_pos(24'sh7FFFFF, 24'sh7FFFFF);
        send_pos(-24'sh800000, -24'sh800000);
        send_pos(-24'sh800000, -24'sh800000);
        send_pos(24'sh7FFFFF, -24'sh800000);
        send_pos(24'sd100, 24'sd0);
        send_pos(24'sd100, 24'sd0);
        wait_idle();
        // window shrink drops the oldest at once; oversized window clamps
        write_reg(REG_HISTORY, 17'd2);
        send_pos(24'sd100, 24'sd0);
        wait_idle();
        write_reg(REG_HISTORY, 17'd1);
        send_pos(24'sd5, 24'sd5);
        wait_idle();
        write_reg(REG_HISTORY, 17'd63);
        write_reg(REG_KERNEL, 17'd1);
        write_reg(REG_DECAY, 17'h1FFFF);
        for (i = 0; i < 6; i++) send_pos(24'(i * 300), 24'(-i * 77));
        wait_idle();
        write_reg(REG_DECAY, 17'd0);
        send_pos(-24'sd1, 24'sd1);
        send_pos(24'sd1, -24'sd1);
        wait_idle();
        write_reg(REG_FIXX, 17'h8000);
        write_reg(REG_FIXY, 17'h7FFF);
        send_pos(24'sd3, 24'sd3);
        wait_idle();
        write_reg(REG_FIXX, 17'd0);
        send_pos(24'sd4, 24'sd4);
        wait_idle();
        write_reg(REG_FIXY, 17'd0);

        // random phases; mostly smooth tracks, some jumps and repeats
        for (i = 0; i < 1900; i++)
        begin
            if (i % 60 == 0)
            begin
                wait_idle();
                random_setting();
                mode = $urandom_range(0, 9);
                bx = rand_coord(0) >>> $urandom_range(0, 12);
                by = rand_coord(0) >>> $urandom_range(0, 12);
            end
            if (i == 500) hold_req = 1;
            burst = $urandom_range(0, 9);
            if (burst == 0)
                send_pos(rand_coord(mode % 3), rand_coord($urandom_range(0, 2)));
            else if (burst == 1)
                send_pos(bx, by);
            else
            begin
                bx = bx + 24'($signed($urandom_range(0, 600)) - 300);
                by = by + 24'($signed($urandom_range(0, 600)) - 200);
                send_pos(bx, by);
            end
            sender_gap();
        end
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Long receiver hold-off counted here while the sender keeps offering.
    always @(posedge hold_req)
    begin
        hold_off = 1;
        repeat (2000) @(negedge clk);
        hold_off = 0;
    end

endmodule

/* filelist.f */
hw/rtl/whe_pkg.sv
hw/rtl/weighted_heading_estimator.sv
tb/whe_checker.sv
tb/tb_top.sv
